[sv/lfk_pkg.sv]
// Shared types and constants for the leg forward kinematics block.
// Fixed-point widths, angle constants and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package lfk_pkg;

  localparam int ANG_W      = 30;   // angle in radians, 24 fractional bits
  localparam int XY_W       = 34;   // CORDIC x/y, 30 fractional bits
  localparam int MAX_STAGES = 24;

  localparam logic signed [ANG_W-1:0] PI_Q24      = 30'sd52707179;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 30'sd26353589;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q24  = 30'sd105414358;
  localparam logic signed [XY_W-1:0]  CORDIC_X0   = 34'sd652032874;

  localparam logic [23:0] ATAN_Q24 [MAX_STAGES] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
    24'd1047214,  24'd524117,  24'd262123,  24'd131069,
    24'd65536,    24'd32768,   24'd16384,   24'd8192,
    24'd4096,     24'd2048,    24'd1024,    24'd512,
    24'd256,      24'd128,     24'd64,      24'd32,
    24'd16,       24'd8,       24'd4,       24'd2
  };

  typedef enum logic [1:0] {
    REG_HIP   = 2'd0,
    REG_UPPER = 2'd1,
    REG_LOWER = 2'd2
  } cfg_reg_t;

endpackage

[sv/lfk_cordic.sv]
// Pipelined rotation-mode CORDIC giving cosine and sine of one angle.
// Uses lfk_pkg for widths, angle constants and the arctangent table.
`timescale 1ns / 1ps

module lfk_cordic
  import lfk_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] angle_i,
  output logic signed [XY_W-1:0]  cos_o,
  output logic signed [XY_W-1:0]  sin_o
);

  logic signed [ANG_W-1:0] z_wrap, z_fold;
  logic                    neg_fold;

  logic signed [XY_W-1:0]  x_r   [STAGES+1];
  logic signed [XY_W-1:0]  y_r   [STAGES+1];
  logic signed [ANG_W-1:0] z_r   [STAGES+1];
  logic                    neg_r [STAGES+1];
  logic signed [XY_W-1:0]  cos_r, sin_r;

  // Wrap once into [-pi, pi], then fold the outer half-planes by pi and
  // remember to negate both results.
  always_comb begin
    z_wrap = angle_i;
    if (angle_i > PI_Q24) begin
      z_wrap = angle_i - TWO_PI_Q24;
    end else if (angle_i < -PI_Q24) begin
      z_wrap = angle_i + TWO_PI_Q24;
    end
    z_fold   = z_wrap;
    neg_fold = 1'b0;
    if (z_wrap > HALF_PI_Q24) begin
      z_fold   = z_wrap - PI_Q24;
      neg_fold = 1'b1;
    end else if (z_wrap < -HALF_PI_Q24) begin
      z_fold   = z_wrap + PI_Q24;
      neg_fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= CORDIC_X0;
      y_r[0]   <= '0;
      z_r[0]   <= z_fold;
      neg_r[0] <= neg_fold;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [ANG_W-1:0] ATAN_I =
      $signed({{(ANG_W-24){1'b0}}, ATAN_Q24[i]});
    logic signed [XY_W-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][ANG_W-1]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - ATAN_I;
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + ATAN_I;
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= neg_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];
      sin_r <= neg_r[STAGES] ? -y_r[STAGES] : y_r[STAGES];
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

[sv/leg_forward_kinematics_top.sv]
// Usage notes:
// Forward kinematics of one three-link leg: joint angles in, foot position
// in the hip frame out. The input channel (in_valid/in_ready) carries the
// abduction, hip and knee angles and the side bit; the result channel
// (out_valid/out_ready) carries foot x, y and z, saturated to +-49149.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
// sets the hip, thigh and shank lengths; cfg_ready is always high, an
// index beyond the three registers is ignored, and a write must only come
// while no transfer is in flight.
// From input transfer to out_valid the data passes through the CORDIC pipeline
// (CORDIC_STAGES + 2), the leg-length stages (2), the 21-step square root,
// and six stages of multiplies and rotation.
// One item is accepted per cycle while the output is not stalled. The whole
// pipeline moves on a common enable; when out_valid is high and out_ready
// low, every stage holds and in_ready drops until the result transfers.
// Reset clears all valid bits and loads the default link lengths.
// Depends on lfk_pkg and lfk_cordic.
`timescale 1ns / 1ps

module leg_forward_kinematics_top
  import lfk_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_abduction_angle,
  input  logic signed [15:0] in_hip_angle,
  input  logic signed [15:0] in_knee_angle,
  input  logic               in_mirror_side,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_foot_x,
  output logic signed [16:0] out_foot_y,
  output logic signed [16:0] out_foot_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [13:0]        cfg_data
);

  localparam int CL   = CORDIC_STAGES + 2;
  localparam int SQ_N = 21;
  localparam logic signed [16:0] OUT_MAX = 17'sd49149;

  typedef struct packed {
    logic signed [XY_W-1:0] ss;
    logic signed [XY_W-1:0] cs;
    logic signed [XY_W-1:0] ca;
    logic signed [XY_W-1:0] sa;
    logic                   mir;
  } side_t;

  function automatic logic signed [16:0] sat17(input logic signed [47:0] v);
    if (v > 48'sd49149) begin
      sat17 = OUT_MAX;
    end else if (v < -48'sd49149) begin
      sat17 = -OUT_MAX;
    end else begin
      sat17 = $signed(v[16:0]);
    end
  endfunction

  logic out_valid_r;
  logic en;
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // ---------------- configuration ----------------
  logic [13:0] hip_r, upper_r, lower_r;
  logic [27:0] ul_r;
  logic [33:0] sumsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hip_r   <= 14'd1311;
      upper_r <= 14'd3277;
      lower_r <= 14'd3277;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HIP:   hip_r   <= cfg_data;
        REG_UPPER: upper_r <= cfg_data;
        REG_LOWER: lower_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Products of the link lengths are registered and follow the length registers in the next cycle.
  always_ff @(posedge clk) begin
    ul_r    <= upper_r * lower_r;
    sumsq_r <= {1'b0, {15'b0, upper_r} * {15'b0, upper_r}
                      + {15'b0, lower_r} * {15'b0, lower_r}, 4'b0};
  end

  // ---------------- angles and CORDIC ----------------
  logic signed [ANG_W-1:0] ab_ang, knee_ang, swing_ang;
  assign ab_ang    = $signed({{3{in_abduction_angle[15]}}, in_abduction_angle, 11'b0});
  assign knee_ang  = $signed({{3{in_knee_angle[15]}}, in_knee_angle, 11'b0});
  assign swing_ang = $signed({{3{in_hip_angle[15]}}, in_hip_angle, 11'b0})
                   + $signed({{4{in_knee_angle[15]}}, in_knee_angle, 10'b0});

  logic signed [XY_W-1:0] ck, cs, ss, ca, sa;

  lfk_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_knee (
    .clk(clk), .en(en), .angle_i(knee_ang), .cos_o(ck), .sin_o()
  );
  lfk_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_swing (
    .clk(clk), .en(en), .angle_i(swing_ang), .cos_o(cs), .sin_o(ss)
  );
  lfk_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_abd (
    .clk(clk), .en(en), .angle_i(ab_ang), .cos_o(ca), .sin_o(sa)
  );

  logic vc_r [CL];
  logic mc_r [CL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CL; k++) vc_r[k] <= 1'b0;
    end else if (en) begin
      vc_r[0] <= in_valid;
      for (int k = 1; k < CL; k++) vc_r[k] <= vc_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mc_r[0] <= in_mirror_side;
      for (int k = 1; k < CL; k++) mc_r[k] <= mc_r[k-1];
    end
  end

  // ---------------- leg length square ----------------
  logic               va_r, vb_r;
  logic signed [62:0] p_r;
  side_t              side_a_r, side_b_r;
  logic [41:0]        n_r;
  logic signed [62:0] p_rnd;
  logic signed [39:0] n_sum;

  assign p_rnd = (p_r + 63'sd16777216) >>> 25;
  assign n_sum = $signed({6'b0, sumsq_r}) + 40'(p_rnd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= vc_r[CL-1];
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r      <= $signed({1'b0, ul_r}) * ck;
      side_a_r <= '{ss: ss, cs: cs, ca: ca, sa: sa, mir: mc_r[CL-1]};
      n_r      <= n_sum[39] ? '0 : {2'b0, n_sum};
      side_b_r <= side_a_r;
    end
  end

  // ---------------- square root, one digit per stage ----------------
  logic [42:0] rem_r  [SQ_N];
  logic [42:0] root_r [SQ_N];
  side_t       side_q_r [SQ_N];
  logic        vq_r [SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam logic [42:0] BIT = 43'd1 << (40 - 2 * k);
    logic [42:0] rem_i, root_i, trial;
    side_t       side_i;
    logic        v_i;

    if (k == 0) begin : g_first
      assign rem_i  = {1'b0, n_r};
      assign root_i = '0;
      assign side_i = side_b_r;
      assign v_i    = vb_r;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign side_i = side_q_r[k-1];
      assign v_i    = vq_r[k-1];
    end

    assign trial = root_i + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vq_r[k] <= 1'b0;
      end else if (en) begin
        vq_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_i >= trial) begin
          rem_r[k]  <= rem_i - trial;
          root_r[k] <= (root_i >> 1) + BIT;
        end else begin
          rem_r[k]  <= rem_i;
          root_r[k] <= root_i >> 1;
        end
        side_q_r[k] <= side_i;
      end
    end
  end

  // ---------------- swing and rotation ----------------
  logic [20:0] len;
  assign len = root_r[SQ_N-1][20:0];

  logic                   vd_r, ve_r, vf_r, vg_r, vh_r;
  logic signed [55:0]     xm_r, zm_r;
  logic signed [XY_W-1:0] ca_d_r, sa_d_r, ca_e_r, sa_e_r;
  logic                   mir_d_r, mir_e_r, mir_f_r;
  logic signed [55:0]     xh, zh;
  logic signed [55:0]     xo_full;
  logic signed [39:0]     zh_r;
  logic signed [16:0]     x_e_r, x_f_r, x_g_r, x_h_r;
  logic signed [48:0]     cy_r, cz_r;
  logic signed [51:0]     ppl_s_r, ppl_c_r;
  logic signed [56:0]     pph_s_r, pph_c_r;
  logic signed [79:0]     sazh_r, cazh_r, yt_r, zt_r;
  logic signed [79:0]     y_full_r, z_full_r;
  logic signed [79:0]     cy_ext, cz_ext;
  logic signed [79:0]     y_rnd, z_rnd;
  logic signed [14:0]     hip_s;
  logic signed [17:0]     zh_lo;
  logic signed [22:0]     zh_hi;
  logic signed [16:0]     foot_x_r, foot_y_r, foot_z_r;

  assign xh      = -((xm_r + 56'sd32768) >>> 16);
  assign zh      = -((zm_r + 56'sd32768) >>> 16);
  assign xo_full = (xh + 56'sd32768) >>> 16;
  assign hip_s   = $signed({1'b0, hip_r});
  assign zh_lo   = $signed({1'b0, zh_r[16:0]});
  assign zh_hi   = zh_r[39:17];
  assign cy_ext  = 80'(cy_r) <<< 16;
  assign cz_ext  = 80'(cz_r) <<< 16;
  assign y_rnd   = (y_full_r + (80'sd1 <<< 45)) >>> 46;
  assign z_rnd   = (z_full_r + (80'sd1 <<< 45)) >>> 46;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r        <= 1'b0;
      ve_r        <= 1'b0;
      vf_r        <= 1'b0;
      vg_r        <= 1'b0;
      vh_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vd_r        <= vq_r[SQ_N-1];
      ve_r        <= vd_r;
      vf_r        <= ve_r;
      vg_r        <= vf_r;
      vh_r        <= vg_r;
      out_valid_r <= vh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Scale the unit swing vector by the leg length.
      xm_r    <= $signed({1'b0, len}) * side_q_r[SQ_N-1].ss;
      zm_r    <= $signed({1'b0, len}) * side_q_r[SQ_N-1].cs;
      ca_d_r  <= side_q_r[SQ_N-1].ca;
      sa_d_r  <= side_q_r[SQ_N-1].sa;
      mir_d_r <= side_q_r[SQ_N-1].mir;

      zh_r    <= 40'(zh);
      x_e_r   <= sat17(48'(xo_full));
      ca_e_r  <= ca_d_r;
      sa_e_r  <= sa_d_r;
      mir_e_r <= mir_d_r;

      // The height term is split into two partial products per factor.
      cy_r    <= ca_e_r * hip_s;
      cz_r    <= sa_e_r * hip_s;
      ppl_s_r <= sa_e_r * zh_lo;
      pph_s_r <= sa_e_r * zh_hi;
      ppl_c_r <= ca_e_r * zh_lo;
      pph_c_r <= ca_e_r * zh_hi;
      x_f_r   <= x_e_r;
      mir_f_r <= mir_e_r;

      sazh_r  <= (80'(pph_s_r) <<< 17) + 80'(ppl_s_r);
      cazh_r  <= (80'(pph_c_r) <<< 17) + 80'(ppl_c_r);
      yt_r    <= mir_f_r ? -cy_ext : cy_ext;
      zt_r    <= mir_f_r ? -cz_ext : cz_ext;
      x_g_r   <= x_f_r;

      y_full_r <= yt_r - sazh_r;
      z_full_r <= zt_r + cazh_r;
      x_h_r    <= x_g_r;

      foot_x_r <= x_h_r;
      foot_y_r <= sat17(48'(y_rnd));
      foot_z_r <= sat17(48'(z_rnd));
    end
  end

  assign out_valid  = out_valid_r;
  assign out_foot_x = foot_x_r;
  assign out_foot_y = foot_y_r;
  assign out_foot_z = foot_z_r;

  // ---------------- assertions ----------------
  a_reset_clears_out: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r)
    else $error("result valid set right after reset");

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_foot_x <= OUT_MAX && out_foot_x >= -OUT_MAX))
    else $error("foot_x beyond saturation limit");

  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_foot_y <= OUT_MAX && out_foot_y >= -OUT_MAX))
    else $error("foot_y beyond saturation limit");

  a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_foot_z <= OUT_MAX && out_foot_z >= -OUT_MAX))
    else $error("foot_z beyond saturation limit");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(vh_r) && $stable(vd_r) && $stable(va_r)))
    else $error("pipeline moved while stalled");

endmodule
